// ----- src/sbf_pkg.sv -----
// shared types, constants and helpers for the spectral band fingerprint block
package sbf_pkg;

  localparam int unsigned NUM_BINS_DEF = 1024;
  localparam int unsigned NBANDS       = 33;
  localparam int unsigned NPAIRS       = 32;
  localparam int unsigned SUM_W        = 48;
  localparam int unsigned BAND_W       = 6;
  localparam int unsigned CNT_W        = 11;
  localparam int unsigned RATE_W       = 16;
  localparam int unsigned X_W          = 28;   // (cnt+1)*sample_rate
  localparam int unsigned THR_W        = 37;   // freq*num_bins compare width
  localparam int unsigned COMP_W       = 32;
  localparam int unsigned RAD_W        = 64;
  localparam int unsigned ROOT_W       = 32;
  localparam int unsigned REM_W        = 34;
  localparam int unsigned WORD_W       = 32;
  localparam logic [RATE_W-1:0] RATE_RST = 16'd5512;

  // band edges in hertz, 8 fraction bits
  localparam logic [18:0] EDGE_Q8 [NBANDS+1] = '{
    19'd76800,  19'd81345,  19'd86158,  19'd91256,  19'd96656,  19'd102375,
    19'd108433, 19'd114850, 19'd121646, 19'd128844, 19'd136468, 19'd144543,
    19'd153096, 19'd162155, 19'd171751, 19'd181914, 19'd192678, 19'd204079,
    19'd216155, 19'd228946, 19'd242493, 19'd256842, 19'd272041, 19'd288138,
    19'd305188, 19'd323246, 19'd342374, 19'd362634, 19'd384092, 19'd406820,
    19'd430892, 19'd456389, 19'd483397, 19'd512000
  };

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_FREQ    = 10'b0000000010,
    ST_SQRE    = 10'b0000000100,
    ST_SQIM    = 10'b0000001000,
    ST_ROOT_GO = 10'b0000010000,
    ST_ROOT    = 10'b0000100000,
    ST_RD      = 10'b0001000000,
    ST_ACC     = 10'b0010000000,
    ST_SWEEP   = 10'b0100000000,
    ST_EMIT    = 10'b1000000000
  } sbf_state_t;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic              in_range;
  } band_info_t;

  // edge scaled by the bin count, so freq compares need no divide
  function automatic logic [THR_W-1:0] edge_thr(input int unsigned q8,
                                                input int unsigned nb);
    logic [63:0] p;
    p = 64'(q8) * 64'(nb);
    return p[THR_W-1:0];
  endfunction

  function automatic logic [COMP_W-1:0] mag32(input logic [COMP_W-1:0] x);
    return x[COMP_W-1] ? (~x + COMP_W'(1)) : x;
  endfunction

endpackage

// ----- src/sbf_ram.sv -----
// generic single write port, single read port ram with registered read
module sbf_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/sbf_isqrt.sv -----
// iterative integer square root, two radicand bits per cycle
module sbf_isqrt import sbf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [4:0]        step_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W+1:0]  shifted;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;

  assign shifted = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign ge      = shifted >= trial;
  assign diff    = shifted - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], ge};
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        step_r <= step_r + 5'd1;
        if (step_r == 5'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- src/sbf_band_scan.sv -----
// range check and band search, one edge compare per cycle
module sbf_band_scan import sbf_pkg::*; #(
  parameter int unsigned NUM_BINS = NUM_BINS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [X_W-1:0] x,
  output band_info_t     info
);

  localparam logic [THR_W-1:0] THR_TOP = edge_thr(int'(EDGE_Q8[NBANDS]) + 1, NUM_BINS);

  logic [THR_W-1:0]  thr [NBANDS+1];
  logic [THR_W-1:0]  xs_in;
  logic [THR_W-1:0]  xs_r;
  logic [4:0]        idx_r;
  logic [BAND_W-1:0] thr_idx;
  logic [BAND_W-1:0] band_r;
  logic              in_range_r;
  logic              busy_r;
  logic              found_r;

  for (genvar g = 0; g < NBANDS + 1; g++) begin : g_thr
    assign thr[g] = edge_thr(int'(EDGE_Q8[g]), NUM_BINS);
  end

  assign xs_in   = THR_W'({x, 8'h00});
  assign thr_idx = BAND_W'(idx_r) + BAND_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      found_r <= 1'b0;
    end else if (start) begin
      xs_r       <= xs_in;
      in_range_r <= (xs_in >= thr[0]) && (xs_in < THR_TOP);
      band_r     <= BAND_W'(NBANDS - 1);
      idx_r      <= '0;
      found_r    <= 1'b0;
      busy_r     <= 1'b1;
    end else if (busy_r) begin
      // first edge above the frequency names the band, top edge falls to the last band
      if (!found_r && (xs_r < thr[thr_idx])) begin
        band_r  <= BAND_W'(idx_r);
        found_r <= 1'b1;
      end
      idx_r <= idx_r + 5'd1;
      if (idx_r == 5'(NPAIRS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign info.band     = band_r;
  assign info.in_range = in_range_r;

endmodule

// ----- src/spectral_band_fingerprint_top.sv -----
// top level: bin sequencer, shared multiplier, band memories and word output
//
// Takes one fft bin per item and adds its magnitude to one of 33 log-spaced
// bands between 300 and 2000 Hz; a bin flagged with tlast closes the frame and
// yields one 32-bit sub-fingerprint word on the output channel. Each bin gets
// one pass each of the shared 32x32 multiplier for the bin frequency, re^2 and
// im^2, then 32 iterations of the square root unit, then a read-modify-write of
// the band memory. A frame-closing bin adds a sweep over the 33 band entries of
// the current and previous frame memories. in_tready is high only between
// items; a finished word waits in the output register while the next bins are
// taken. The configuration channel is always ready and should only be written
// between items.
module spectral_band_fingerprint_top import sbf_pkg::*; #(
  parameter int unsigned NUM_BINS = NUM_BINS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       in_tdata,   // bin_real[31:0], bin_imag[63:32]
  input  logic              in_tlast,
  input  logic              in_tuser,   // track_start[0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [WORD_W-1:0] out_tdata,  // fingerprint_word[31:0]
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [RATE_W-1:0] cfg_data
);

  sbf_state_t         state_r, state_nxt;
  logic [RATE_W-1:0]  sample_rate_r;
  logic [COMP_W-1:0]  re_r, im_r;
  logic               last_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               first_r;
  logic [RAD_W-1:0]   mul_p_r;
  logic [RAD_W-1:0]   sq_r;
  logic [COMP_W-1:0]  mul_a, mul_b;
  logic [NBANDS-1:0]  valid_r;
  logic               e_vld_rd_r;
  logic [BAND_W-1:0]  sw_idx_r;
  logic               p1_vld_r, p2_vld_r;
  logic [BAND_W-1:0]  p1_idx_r, p2_idx_r;
  logic signed [SUM_W:0]   s_r, s_prev_r, s_new;
  logic signed [SUM_W+1:0] d;
  logic               d_pos;
  logic [4:0]         bit_pos;
  logic [BAND_W-1:0]  bit_calc;
  logic [WORD_W-1:0]  word_r;
  logic               out_valid_r;
  logic [WORD_W-1:0]  out_data_r;
  logic               accept;
  logic               emit_ok;
  logic               sqrt_done;
  logic [ROOT_W-1:0]  root;
  band_info_t         binfo;
  logic [BAND_W-1:0]  raddr;
  logic [SUM_W-1:0]   e_rd, p_rd, e_eff;
  logic [SUM_W:0]     acc_sum;
  logic [SUM_W-1:0]   acc_sat;
  logic               e_we;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign emit_ok   = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      sample_rate_r <= cfg_data;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (accept) state_nxt = ST_FREQ;
      ST_FREQ:    state_nxt = ST_SQRE;
      ST_SQRE:    state_nxt = ST_SQIM;
      ST_SQIM:    state_nxt = ST_ROOT_GO;
      ST_ROOT_GO: state_nxt = ST_ROOT;
      ST_ROOT:    if (sqrt_done) state_nxt = ST_RD;
      ST_RD:      state_nxt = ST_ACC;
      ST_ACC:     state_nxt = last_r ? ST_SWEEP : ST_IDLE;
      ST_SWEEP:   if (p2_vld_r && (p2_idx_r == BAND_W'(NBANDS - 1))) state_nxt = ST_EMIT;
      ST_EMIT:    if (emit_ok) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      re_r   <= mag32(in_tdata[31:0]);
      im_r   <= mag32(in_tdata[63:32]);
      last_r <= in_tlast;
    end
  end

  // shared multiplier: bin frequency, then re^2, then im^2
  always_comb begin
    unique case (state_r)
      ST_FREQ: begin
        mul_a = COMP_W'(cnt_r) + COMP_W'(1);
        mul_b = COMP_W'(sample_rate_r);
      end
      ST_SQRE: begin
        mul_a = re_r;
        mul_b = re_r;
      end
      default: begin
        mul_a = im_r;
        mul_b = im_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= RAD_W'(mul_a) * RAD_W'(mul_b);
    if (state_r == ST_SQIM) begin
      sq_r <= mul_p_r;
    end
  end

  sbf_band_scan #(.NUM_BINS(NUM_BINS)) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_SQRE),
    .x     (mul_p_r[X_W-1:0]),
    .info  (binfo)
  );

  sbf_isqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_ROOT_GO),
    .radicand (sq_r + mul_p_r),
    .done     (sqrt_done),
    .root     (root)
  );

  // band memories
  assign raddr = ((state_r == ST_SWEEP) && (sw_idx_r < BAND_W'(NBANDS))) ? sw_idx_r
                                                                          : binfo.band;
  assign e_eff   = e_vld_rd_r ? e_rd : '0;
  assign acc_sum = {1'b0, e_eff} + (SUM_W + 1)'(root);
  assign acc_sat = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
  assign e_we    = (state_r == ST_ACC) && binfo.in_range;

  sbf_ram #(.WIDTH(SUM_W), .DEPTH(NBANDS)) u_band_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (binfo.band),
    .wdata (acc_sat),
    .raddr (raddr),
    .rdata (e_rd)
  );

  sbf_ram #(.WIDTH(SUM_W), .DEPTH(NBANDS)) u_prior_ram (
    .clk   (clk),
    .we    (p1_vld_r),
    .waddr (p1_idx_r),
    .wdata (e_eff),
    .raddr (raddr),
    .rdata (p_rd)
  );

  always_ff @(posedge clk) begin
    e_vld_rd_r <= valid_r[raddr];
  end

  // frame control: bin counter, entry valid bits, first-frame flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      first_r <= 1'b1;
      valid_r <= '0;
    end else if (accept && in_tuser) begin
      cnt_r   <= '0;
      first_r <= 1'b1;
      valid_r <= '0;
    end else if (state_r == ST_ACC) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (binfo.in_range) begin
        valid_r[binfo.band] <= 1'b1;
      end
    end else if ((state_r == ST_EMIT) && emit_ok) begin
      cnt_r   <= '0;
      first_r <= 1'b0;
      valid_r <= '0;
    end
  end

  // frame-end sweep: s[j] = E[j] - P[j] (P as zero in the first frame), bit set when s[j-1] - s[j] > 0
  assign s_new    = $signed({1'b0, e_eff}) - (first_r ? '0 : $signed({1'b0, p_rd}));
  assign d        = {s_prev_r[SUM_W], s_prev_r} - {s_r[SUM_W], s_r};
  assign d_pos    = !d[SUM_W+1] && (d != '0);
  assign bit_calc = BAND_W'(NPAIRS) - p2_idx_r;
  assign bit_pos  = bit_calc[4:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      sw_idx_r <= '0;
    end else if ((state_r == ST_ACC) && last_r) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      sw_idx_r <= '0;
      word_r   <= '0;
    end else if (state_r == ST_SWEEP) begin
      p1_vld_r <= sw_idx_r < BAND_W'(NBANDS);
      p1_idx_r <= sw_idx_r;
      if (sw_idx_r < BAND_W'(NBANDS)) begin
        sw_idx_r <= sw_idx_r + BAND_W'(1);
      end
      p2_vld_r <= p1_vld_r;
      p2_idx_r <= p1_idx_r;
      if (p1_vld_r) begin
        s_prev_r <= s_r;
        s_r      <= s_new;
      end
      if (p2_vld_r && (p2_idx_r != '0)) begin
        word_r[bit_pos] <= d_pos;
      end
    end else begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_EMIT) && emit_ok) begin
      out_valid_r <= 1'b1;
      out_data_r  <= word_r;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- src/sbf_checker.sv -----
// port-level checks for the fingerprint top level, bound to it
module sbf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed or dropped");

  a_busy_after_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after taking a bin");

  a_no_instant_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("fingerprint word appeared one cycle after a bin");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready && cfg_ready)
    else $error("block not idle after reset");

endmodule

bind spectral_band_fingerprint_top sbf_checker u_sbf_checker (.*);

// ----- dv/spectral_band_fingerprint_top_test.sv -----
// self-checking testbench for the spectral band fingerprint top level
module spectral_band_fingerprint_top_test import sbf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BINS          = 1024;
  localparam int unsigned BANDS         = 33;
  localparam logic [63:0] SUM_CAP       = 64'hFFFF_FFFF_FFFF;
  localparam int          SETTLE_CYCLES = 150;
  localparam int          HOLD_CYCLES   = 1500;
  localparam int          STALL_LIMIT   = 10000;
  localparam int          RANDOM_ITEMS  = 560;
  localparam int          RANDOM_WORDS  = 20;

  // band edges in hertz with 8 fraction bits
  localparam logic [18:0] BAND_EDGE [BANDS+1] = '{
    19'd76800,  19'd81345,  19'd86158,  19'd91256,  19'd96656,  19'd102375,
    19'd108433, 19'd114850, 19'd121646, 19'd128844, 19'd136468, 19'd144543,
    19'd153096, 19'd162155, 19'd171751, 19'd181914, 19'd192678, 19'd204079,
    19'd216155, 19'd228946, 19'd242493, 19'd256842, 19'd272041, 19'd288138,
    19'd305188, 19'd323246, 19'd342374, 19'd362634, 19'd384092, 19'd406820,
    19'd430892, 19'd456389, 19'd483397, 19'd512000
  };

  typedef enum int {RX_OPEN, RX_COIN, RX_RUNS, RX_COMB} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [63:0]       in_tdata;   // bin_real[31:0], bin_imag[63:32]
  logic              in_tlast;
  logic              in_tuser;   // track_start[0]
  logic              out_tvalid;
  logic              out_tready;
  logic [WORD_W-1:0] out_tdata;  // fingerprint_word[31:0]
  logic              cfg_valid;
  logic              cfg_ready;
  logic [RATE_W-1:0] cfg_data;

  spectral_band_fingerprint_top #(.NUM_BINS(BINS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // predicted block state
  logic [RATE_W-1:0] rate_q = 16'd5512;
  logic [47:0]       sum_q [BANDS];
  logic [47:0]       prior_q [BANDS];
  logic [10:0]       cnt_q = '0;
  bit                first_q = 1'b1;
  logic [31:0]       fingerprint_q [$];

  int  mismatch_count = 0;
  int  words_predicted = 0;
  int  idle_cycles = 0;
  bit  hold_req = 1'b0;
  bit  valid_hold = 1'b0;
  int  burst_left = 0;
  int  gap_cnt = 0;

  initial foreach (sum_q[j]) sum_q[j] = '0;

  function automatic logic [63:0] abs_part(input logic [31:0] x);
    logic [31:0] n;
    n = ~x + 32'd1;
    return x[31] ? {32'd0, n} : {32'd0, x};
  endfunction

  function automatic logic [31:0] root_floor(input logic [63:0] v);
    logic [31:0] r;
    logic [31:0] trial;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = r | (32'd1 << i);
      if ({32'd0, trial} * {32'd0, trial} <= v) r = trial;
    end
    return r;
  endfunction

  // adds one accepted bin to the predicted band sums, queues a word on frame end
  task automatic fold_bin(input logic [31:0] re, input logic [31:0] im,
                          input bit last, input bit start);
    logic [63:0] freq;
    logic [63:0] mag;
    logic [63:0] room;
    logic [31:0] word;
    longint      diff;
    int          band;
    if (start) begin
      foreach (sum_q[j]) sum_q[j] = '0;
      cnt_q = '0;
      first_q = 1'b1;
    end
    freq = (({53'd0, cnt_q} + 64'd1) * {48'd0, rate_q} * 64'd256) / 64'(BINS);
    if (freq >= {45'd0, BAND_EDGE[0]} && freq <= {45'd0, BAND_EDGE[BANDS]}) begin
      mag = {32'd0, root_floor(abs_part(re) * abs_part(re) + abs_part(im) * abs_part(im))};
      band = BANDS - 1;
      for (int j = BANDS - 1; j >= 0; j--)
        if (freq < {45'd0, BAND_EDGE[j+1]}) band = j;
      room = SUM_CAP - {16'd0, sum_q[band]};
      if (room < mag) sum_q[band] = SUM_CAP[47:0];
      else sum_q[band] = sum_q[band] + mag[47:0];
    end
    cnt_q = cnt_q + 11'd1;
    if (last) begin
      word = '0;
      for (int j = 0; j < BANDS - 1; j++) begin
        diff = longint'({16'd0, sum_q[j]}) - longint'({16'd0, sum_q[j+1]});
        if (!first_q)
          diff -= longint'({16'd0, prior_q[j]}) - longint'({16'd0, prior_q[j+1]});
        if (diff > 0) word[31-j] = 1'b1;
      end
      fingerprint_q = {fingerprint_q, word};
      words_predicted++;
      foreach (sum_q[j]) begin
        prior_q[j] = sum_q[j];
        sum_q[j] = '0;
      end
      cnt_q = '0;
      first_q = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (fingerprint_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %08h", out_tdata));
      end else begin
        if (out_tdata !== fingerprint_q[0])
          report_mismatch($sformatf("fingerprint_word got %08h want %08h",
                                    out_tdata, fingerprint_q[0]));
        void'(fingerprint_q.pop_front());
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: changing stall pattern, plus one long hold on request
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       run_left;
    int       tick;
    bit       level;
    out_tready = 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    run_left = 0;
    tick = 0;
    level = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_OPEN: out_tready <= 1'b1;
          RX_COIN: out_tready <= 1'($urandom_range(0, 1));
          RX_RUNS: begin
            if (run_left == 0) begin
              level = ~level;
              run_left = level ? $urandom_range(1, 10) : $urandom_range(1, 60);
            end
            run_left--;
            out_tready <= level;
          end
          default: out_tready <= (tick % 7) >= 3;
        endcase
      end
    end
  end

  function automatic logic [31:0] pick_sample();
    logic [31:0] tmp;
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(0, 2000) - 1000);
      3: begin
        tmp = $urandom() >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? ~tmp + 32'd1 : tmp;
      end
      default: return $urandom();
    endcase
  endfunction

  // sends one bin; called and returns at a falling edge
  task automatic send_bin(input logic [31:0] re, input logic [31:0] im,
                          input bit last, input bit start);
    if (!valid_hold) begin
      repeat (gap_cnt) @(negedge clk);
      gap_cnt = 0;
    end
    in_tdata  <= {im, re};
    in_tlast  <= last;
    in_tuser  <= start;
    in_tvalid <= 1'b1;
    valid_hold = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fold_bin(re, im, last, start);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 12);
      gap_cnt = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25);
      if (gap_cnt > 0) begin
        in_tvalid <= 1'b0;
        valid_hold = 1'b0;
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic stop_sending();
    if (valid_hold) begin
      in_tvalid <= 1'b0;
      valid_hold = 1'b0;
    end
  endtask

  // block is idle once every word is out and the last bin has run through
  task automatic wait_idle();
    stop_sending();
    while (fingerprint_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] rate);
    cfg_data  <= rate;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rate_q = rate;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input int len, input bit start_first, input bit restarts);
    bit start;
    for (int i = 0; i < len; i++) begin
      start = (i == 0 && start_first) || (restarts && i > 0 && $urandom_range(0, 59) == 0);
      send_bin(pick_sample(), pick_sample(), i == len - 1, start);
    end
  endtask

  // 62.5 Hz per bin: bin 32 lands exactly on the 2000 Hz top edge
  task automatic test_band_edges();
    logic [31:0] pole [5];
    pole = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1};
    wait_idle();
    write_rate(16'd64000);
    for (int i = 0; i < 33; i++)
      send_bin(pole[i % 5], pole[(i / 5) % 5], i == 32, i == 0);
  endtask

  // bin 5 at this rate sits exactly on the 300 Hz lower edge
  task automatic test_low_edge();
    wait_idle();
    write_rate(16'd61440);
    send_frame(6, 1'b0, 1'b0);
  endtask

  task automatic test_track_start();
    wait_idle();
    write_rate(16'hFFFF);
    send_frame(8, 1'b1, 1'b0);
    for (int i = 0; i < 8; i++)
      send_bin(pick_sample(), pick_sample(), i == 7, i == 3);
    send_frame(8, 1'b0, 1'b0);
    send_bin(pick_sample(), pick_sample(), 1'b1, 1'b1);
    send_frame(6, 1'b0, 1'b0);
  endtask

  task automatic test_zero_rate();
    wait_idle();
    write_rate(16'd0);
    send_frame(6, 1'b0, 1'b0);
    wait_idle();
    write_rate(16'd1);
    send_frame(4, 1'b0, 1'b0);
  endtask

  // receiver holds off while short frames keep coming, so the input backs up
  task automatic test_output_hold();
    wait_idle();
    write_rate(16'hFFFF);
    hold_req = 1'b1;
    for (int f = 0; f < 6; f++) send_frame(3, 1'b0, 1'b0);
  endtask

  task automatic test_random_frames();
    int          sent;
    int          words_at_start;
    int          phase;
    int          phase_items;
    int          phase_len;
    int          top;
    int          len;
    logic [15:0] rate;
    sent = 0;
    words_at_start = words_predicted;
    phase = 0;
    while (sent < RANDOM_ITEMS || words_predicted - words_at_start < RANDOM_WORDS) begin
      wait_idle();
      case (phase)
        0: rate = 16'hFFFF;
        1: rate = 16'd1;
        default: rate = $urandom_range(0, 3) == 0 ? 16'($urandom_range(150, 65535))
                                                  : 16'($urandom_range(30000, 65535));
      endcase
      write_rate(rate);
      phase_len = phase == 1 ? 30 : $urandom_range(60, 140);
      phase_items = 0;
      while (phase_items < phase_len) begin
        top = 2048000 / rate + 3;
        if (top > 80) top = 80;
        len = $urandom_range(0, 7) == 0 ? $urandom_range(1, 3) : $urandom_range(1, top);
        send_frame(len, $urandom_range(0, 11) == 0, 1'b1);
        phase_items += len;
      end
      sent += phase_items;
      phase++;
    end
  endtask

  initial begin
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    in_tuser  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_band_edges();
    test_low_edge();
    test_track_start();
    test_zero_rate();
    test_output_hold();
    test_random_frames();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
